FILE: src/thal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thal_pkg
// Types and constants shared by the temperature alarm logger blocks.
// ----------------------------------------------------------------------------
package thal_pkg;

   // commands carried in tuser
   typedef enum logic [1:0] {
      CMD_MEASURE = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_READ    = 2'd2,
      CMD_NOP     = 2'd3
   } thal_cmd_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ALARM_THRESHOLD   = 2'd0,
      CSR_RELEASE_THRESHOLD = 2'd1,
      CSR_BLINK_PERIOD      = 2'd2
   } thal_csr_type;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int ADC_W      = 12;
   localparam int TIME_W     = 32;
   localparam int TEMP_W     = 8;
   localparam int PERIOD_W   = 16;
   localparam int CMD_W      = 2;

   // sensor scaling: 3.3 V span at 50 degrees per volt, 100 degrees at zero code
   localparam int ADC_FULL_SCALE = 4095;
   localparam int TEMP_SPAN      = 100;
   localparam int TEMP_SLOPE     = 165;
   localparam int SPAN_SCALED    = TEMP_SPAN * ADC_FULL_SCALE;
   localparam int SCALED_W       = 20;
   localparam int QUOT_W         = 8;
   localparam int REM_W          = 13;
   localparam int TEMP_WIDE_W    = 10;
   localparam int RECIP_SHIFT    = 32;
   localparam int RECIP_W        = 21;
   localparam logic [RECIP_W-1:0] ADC_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / ADC_FULL_SCALE);

   // duration in seconds: divide by 8, then by 125
   localparam int MS_PER_S        = 1000;
   localparam int DUR_PRESHIFT    = 3;
   localparam int DUR_DIVISOR     = MS_PER_S >> DUR_PRESHIFT;
   localparam int DUR_W           = 23;
   localparam int DUR_Y_W         = TIME_W - DUR_PRESHIFT;
   localparam int DUR_RECIP_SHIFT = 29;
   localparam int DUR_REM_W       = 8;
   localparam logic [DUR_W-1:0] DUR_RECIP =
      DUR_W'((64'd1 << DUR_RECIP_SHIFT) / DUR_DIVISOR);

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [7:0] alarm_threshold;
      logic signed [7:0] release_threshold;
      logic [PERIOD_W-1:0] blink_period_ms;
   } thal_cfg_type;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } thal_date_type;

   typedef struct packed {
      logic signed [7:0] threshold;
      thal_date_type     date;
   } thal_event_type;

   typedef struct packed {
      thal_cmd_type             cmd;
      logic signed [TEMP_W-1:0] temperature;
      logic                     alarm_set;
      logic                     alarm_clear;
      logic [TIME_W-1:0]        now_ms;
      thal_event_type           evt;
   } thal_item_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     alarm_active;
      logic                     led_on;
   } thal_status_type;

endpackage

FILE: src/thal_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thal_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module thal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/thal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thal_front
// Accepts items, converts the sample to degrees in three stages and
// classifies it against the thresholds, then pushes it to the queue.
// ----------------------------------------------------------------------------
module thal_front
   import thal_pkg::*;
#(
   parameter int HISTORY_DEPTH = 64,
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  thal_cfg_type         cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  thal_cmd_type         in_cmd,
   input  logic [ADC_W-1:0]     in_sample,
   input  logic [TIME_W-1:0]    in_now,
   input  thal_date_type        in_date,
   input  logic [IDX_W-1:0]     in_idx,
   input  logic                 credit_return,
   output logic                 push_valid,
   output thal_item_type        push_item,
   output logic [IDX_W-1:0]     push_idx
);

   logic                   accept;
   logic [QUEUE_CNT_W-1:0] used_ff;
   logic [QUEUE_CNT_W-1:0] used_in;

   logic                s1_valid_ff;
   thal_cmd_type        s1_cmd_ff;
   logic [SCALED_W-1:0] s1_scaled_ff;
   logic [TIME_W-1:0]   s1_now_ff;
   thal_date_type       s1_date_ff;
   logic [IDX_W-1:0]    s1_idx_ff;

   logic                s2_valid_ff;
   thal_cmd_type        s2_cmd_ff;
   logic [SCALED_W-1:0] s2_scaled_ff;
   logic [QUOT_W-1:0]   s2_quot_ff;
   logic [TIME_W-1:0]   s2_now_ff;
   thal_date_type       s2_date_ff;
   logic [IDX_W-1:0]    s2_idx_ff;

   logic                s3_valid_ff;
   thal_cmd_type        s3_cmd_ff;
   logic                s3_pos_ff;
   logic [QUOT_W-1:0]   s3_quot_ff;
   logic [REM_W-1:0]    s3_rem_ff;
   logic [TIME_W-1:0]   s3_now_ff;
   thal_date_type       s3_date_ff;
   logic [IDX_W-1:0]    s3_idx_ff;

   logic [SCALED_W+RECIP_W-1:0] recip_prod;
   logic [SCALED_W-1:0]         back_prod;
   logic [SCALED_W-1:0]         rem_wide;

   logic                         rem_ge;
   logic [QUOT_W-1:0]            quot;
   logic [REM_W-1:0]             rem_fix;
   logic                         round_up;
   logic [TEMP_WIDE_W-1:0]       temp_wide;
   logic signed [TEMP_WIDE_W-1:0] temp_signed;
   logic signed [TEMP_W-1:0]     temp;
   logic                         above;
   logic                         hit_set;
   logic                         hit_clear;

   // credits cover the three stages and the queue
   assign in_ready = (used_ff < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept   = in_valid && in_ready;
   assign used_in  = used_ff + QUEUE_CNT_W'(accept) - QUEUE_CNT_W'(credit_return);

   assign recip_prod = (SCALED_W+RECIP_W)'(s1_scaled_ff) * (SCALED_W+RECIP_W)'(ADC_RECIP);
   assign back_prod  = SCALED_W'(s2_quot_ff) * SCALED_W'(ADC_FULL_SCALE);
   assign rem_wide   = s2_scaled_ff - back_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         used_ff     <= used_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff    <= in_cmd;
      s1_scaled_ff <= SCALED_W'(in_sample) * SCALED_W'(TEMP_SLOPE);
      s1_now_ff    <= in_now;
      s1_date_ff   <= in_date;
      s1_idx_ff    <= in_idx;

      s2_cmd_ff    <= s1_cmd_ff;
      s2_scaled_ff <= s1_scaled_ff;
      s2_quot_ff   <= recip_prod[RECIP_SHIFT +: QUOT_W];
      s2_now_ff    <= s1_now_ff;
      s2_date_ff   <= s1_date_ff;
      s2_idx_ff    <= s1_idx_ff;

      s3_cmd_ff    <= s2_cmd_ff;
      s3_pos_ff    <= (s2_scaled_ff <= SCALED_W'(SPAN_SCALED));
      s3_quot_ff   <= s2_quot_ff;
      s3_rem_ff    <= rem_wide[REM_W-1:0];
      s3_now_ff    <= s2_now_ff;
      s3_date_ff   <= s2_date_ff;
      s3_idx_ff    <= s2_idx_ff;
   end

   // quotient estimate may be one low; truncation toward zero for positive values
   always_comb begin
      rem_ge      = (s3_rem_ff >= REM_W'(ADC_FULL_SCALE));
      quot        = s3_quot_ff + QUOT_W'(rem_ge);
      rem_fix     = rem_ge ? (s3_rem_ff - REM_W'(ADC_FULL_SCALE)) : s3_rem_ff;
      round_up    = s3_pos_ff && (rem_fix != '0);
      temp_wide   = TEMP_WIDE_W'(TEMP_SPAN) - TEMP_WIDE_W'(quot) - TEMP_WIDE_W'(round_up);
      temp_signed = $signed(temp_wide);
      if (temp_signed > TEMP_WIDE_W'(signed'(127))) begin
         temp = 8'sd127;
      end else if (temp_signed < -TEMP_WIDE_W'(signed'(128))) begin
         temp = -8'sd128;
      end else begin
         temp = temp_signed[TEMP_W-1:0];
      end
      above = (cfg.alarm_threshold > cfg.release_threshold);
      if (above) begin
         hit_set   = (temp >= cfg.alarm_threshold);
         hit_clear = (temp <= cfg.release_threshold);
      end else begin
         hit_set   = (temp <= cfg.alarm_threshold);
         hit_clear = (temp >= cfg.release_threshold);
      end
   end

   assign push_valid            = s3_valid_ff;
   assign push_item.cmd         = s3_cmd_ff;
   assign push_item.temperature = temp;
   assign push_item.alarm_set   = hit_set;
   assign push_item.alarm_clear = !hit_set && hit_clear;
   assign push_item.now_ms      = s3_now_ff;
   assign push_item.evt.threshold = cfg.alarm_threshold;
   assign push_item.evt.date    = s3_date_ff;
   assign push_idx              = s3_idx_ff;

endmodule

FILE: src/thal_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thal_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module thal_queue
   import thal_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   logic [WIDTH-1:0]       mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign count_in = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

endmodule

FILE: src/thal_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thal_back
// Alarm state, LED blinking and event log; duration division and log
// access run in a short pipeline ahead of the result register.
// ----------------------------------------------------------------------------
module thal_back
   import thal_pkg::*;
#(
   parameter int HISTORY_DEPTH = 64,
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [PERIOD_W-1:0]  blink_period_ms,
   input  logic                 head_valid,
   input  thal_item_type        head_item,
   input  logic [IDX_W-1:0]     head_idx,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output thal_status_type      out_status,
   output logic [CNT_W-1:0]     out_count,
   output thal_event_type       out_entry,
   output logic [DUR_W-1:0]     out_duration
);

   localparam int EVT_W = $bits(thal_event_type);

   logic advance;

   logic                     alarm_ff, alarm_in;
   logic                     led_ff, led_in;
   logic [TIME_W-1:0]        mark_ff, mark_in;
   logic [TIME_W-1:0]        onset_ff, onset_in;
   logic                     logged_ff, logged_in;
   logic [CNT_W-1:0]         total_ff, total_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;

   logic [TIME_W-1:0] held_ms;
   logic [TIME_W-1:0] blink_gap;
   logic [CNT_W-1:0]  total_last;
   logic              log_room;
   logic              evt_we;
   logic              dur_we;
   logic              dur_zero;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_hit;

   logic                p1_valid_ff;
   thal_status_type     p1_status_ff;
   logic [CNT_W-1:0]    p1_count_ff;
   logic                p1_hit_ff;
   logic [IDX_W-1:0]    p1_rd_addr_ff;
   logic                p1_evt_we_ff;
   logic                p1_dur_we_ff;
   logic                p1_dur_zero_ff;
   logic [IDX_W-1:0]    p1_wr_addr_ff;
   thal_event_type      p1_evt_ff;
   logic [DUR_Y_W-1:0]  p1_held_ff;

   logic                p2_valid_ff;
   thal_status_type     p2_status_ff;
   logic [CNT_W-1:0]    p2_count_ff;
   logic                p2_hit_ff;
   logic [IDX_W-1:0]    p2_rd_addr_ff;
   logic                p2_evt_we_ff;
   logic                p2_dur_we_ff;
   logic                p2_dur_zero_ff;
   logic [IDX_W-1:0]    p2_wr_addr_ff;
   thal_event_type      p2_evt_ff;
   logic [DUR_Y_W-1:0]  p2_held_ff;
   logic [DUR_W-1:0]    p2_quot_ff;

   logic                o_valid_ff;
   thal_status_type     o_status_ff;
   logic [CNT_W-1:0]    o_count_ff;
   logic                o_hit_ff;

   logic [DUR_Y_W+DUR_W-1:0] dur_recip_prod;
   logic [DUR_Y_W-1:0]       dur_back_prod;
   logic [DUR_Y_W-1:0]       dur_rem_wide;
   logic [DUR_REM_W-1:0]     dur_rem;
   logic [DUR_W-1:0]         dur_secs;
   logic [DUR_W-1:0]         dur_wdata;
   logic                     ram_evt_we;
   logic                     ram_dur_we;
   logic [EVT_W-1:0]         evt_rdata;
   logic [DUR_W-1:0]         dur_rdata;

   assign advance = !o_valid_ff || out_ready;
   assign pop     = advance && head_valid;

   always_comb begin
      alarm_in   = alarm_ff;
      led_in     = led_ff;
      mark_in    = mark_ff;
      onset_in   = onset_ff;
      logged_in  = logged_ff;
      total_in   = total_ff;
      temp_in    = temp_ff;
      evt_we     = 1'b0;
      dur_we     = 1'b0;
      dur_zero   = 1'b0;
      wr_addr    = '0;
      rd_hit     = 1'b0;
      held_ms    = head_item.now_ms - onset_ff;
      blink_gap  = head_item.now_ms - mark_ff;
      total_last = total_ff - 1'b1;
      log_room   = (total_ff < CNT_W'(HISTORY_DEPTH));
      case (head_item.cmd)
         CMD_MEASURE: begin
            temp_in = head_item.temperature;
            if (head_item.alarm_set) begin
               if (!alarm_ff) begin
                  onset_in = head_item.now_ms;
                  if (log_room) begin
                     evt_we    = 1'b1;
                     dur_we    = 1'b1;
                     dur_zero  = 1'b1;
                     wr_addr   = total_ff[IDX_W-1:0];
                     total_in  = total_ff + 1'b1;
                     logged_in = 1'b1;
                  end else begin
                     logged_in = 1'b0;
                  end
               end
               alarm_in = 1'b1;
            end else if (head_item.alarm_clear) begin
               if (alarm_ff && logged_ff && (total_ff != '0)) begin
                  dur_we  = 1'b1;
                  wr_addr = total_last[IDX_W-1:0];
               end
               alarm_in  = 1'b0;
               logged_in = 1'b0;
            end
            if (alarm_in) begin
               if (blink_gap >= TIME_W'(blink_period_ms)) begin
                  led_in  = !led_ff;
                  mark_in = head_item.now_ms;
               end
            end else begin
               led_in = 1'b0;
            end
         end
         CMD_CLEAR: begin
            total_in  = '0;
            logged_in = 1'b0;
         end
         CMD_READ: begin
            rd_hit = (CNT_W'(head_idx) < total_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alarm_ff  <= 1'b0;
         led_ff    <= 1'b0;
         mark_ff   <= '0;
         onset_ff  <= '0;
         logged_ff <= 1'b0;
         total_ff  <= '0;
         temp_ff   <= '0;
      end else if (pop) begin
         alarm_ff  <= alarm_in;
         led_ff    <= led_in;
         mark_ff   <= mark_in;
         onset_ff  <= onset_in;
         logged_ff <= logged_in;
         total_ff  <= total_in;
         temp_ff   <= temp_in;
      end
   end

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= head_valid;
         p2_valid_ff <= p1_valid_ff;
         o_valid_ff  <= p2_valid_ff;
      end
   end

   assign dur_recip_prod = (DUR_Y_W+DUR_W)'(p1_held_ff) * (DUR_Y_W+DUR_W)'(DUR_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_status_ff.temperature  <= temp_in;
         p1_status_ff.alarm_active <= alarm_in;
         p1_status_ff.led_on       <= led_in;
         p1_count_ff    <= total_in;
         p1_hit_ff      <= rd_hit;
         p1_rd_addr_ff  <= head_idx;
         p1_evt_we_ff   <= evt_we;
         p1_dur_we_ff   <= dur_we;
         p1_dur_zero_ff <= dur_zero;
         p1_wr_addr_ff  <= wr_addr;
         p1_evt_ff      <= head_item.evt;
         p1_held_ff     <= held_ms[TIME_W-1:DUR_PRESHIFT];

         p2_status_ff   <= p1_status_ff;
         p2_count_ff    <= p1_count_ff;
         p2_hit_ff      <= p1_hit_ff;
         p2_rd_addr_ff  <= p1_rd_addr_ff;
         p2_evt_we_ff   <= p1_evt_we_ff;
         p2_dur_we_ff   <= p1_dur_we_ff;
         p2_dur_zero_ff <= p1_dur_zero_ff;
         p2_wr_addr_ff  <= p1_wr_addr_ff;
         p2_evt_ff      <= p1_evt_ff;
         p2_held_ff     <= p1_held_ff;
         p2_quot_ff     <= dur_recip_prod[DUR_RECIP_SHIFT +: DUR_W];

         o_status_ff    <= p2_status_ff;
         o_count_ff     <= p2_count_ff;
         o_hit_ff       <= p2_hit_ff;
      end
   end

   // quotient estimate may be one low
   always_comb begin
      dur_back_prod = DUR_Y_W'(p2_quot_ff) * DUR_Y_W'(DUR_DIVISOR);
      dur_rem_wide  = p2_held_ff - dur_back_prod;
      dur_rem       = dur_rem_wide[DUR_REM_W-1:0];
      dur_secs      = p2_quot_ff + DUR_W'(dur_rem >= DUR_REM_W'(DUR_DIVISOR));
      dur_wdata     = p2_dur_zero_ff ? '0 : dur_secs;
   end

   assign ram_evt_we = advance && p2_valid_ff && p2_evt_we_ff;
   assign ram_dur_we = advance && p2_valid_ff && p2_dur_we_ff;

   thal_ram #(
      .WIDTH (EVT_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_evt_ram (
      .clock   (clock),
      .wr_en   (ram_evt_we),
      .wr_addr (p2_wr_addr_ff),
      .wr_data (p2_evt_ff),
      .rd_en   (advance),
      .rd_addr (p2_rd_addr_ff),
      .rd_data (evt_rdata)
   );

   thal_ram #(
      .WIDTH (DUR_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_dur_ram (
      .clock   (clock),
      .wr_en   (ram_dur_we),
      .wr_addr (p2_wr_addr_ff),
      .wr_data (dur_wdata),
      .rd_en   (advance),
      .rd_addr (p2_rd_addr_ff),
      .rd_data (dur_rdata)
   );

   assign out_valid    = o_valid_ff;
   assign out_status   = o_status_ff;
   assign out_count    = o_count_ff;
   assign out_entry    = o_hit_ff ? thal_event_type'(evt_rdata) : '0;
   assign out_duration = o_hit_ff ? dur_rdata : '0;

endmodule

FILE: src/temperature_hysteresis_alarm_logger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_hysteresis_alarm_logger_unit
// Temperature alarm with hysteresis, blinking LED and an event log.
//
//   channel  direction  ports                     content
//   req      in         req_tvalid/tready/tdata   sample, time, date, index
//                       req_tuser                 command
//   rsp      out        rsp_tvalid/tready/tdata   temperature, alarm, log entry
//   csr      in         csr_we/addr/wdata         threshold and blink registers
//
// one transfer per cycle in each direction when neither side stalls
// path from a req transfer to its rsp: three conversion stages,
// the queue, the state stage, the duration divider and the log read
// an eight entry credit window spans the conversion stages and the queue
// the log needs no clearing after reset; entries above the count are never read
// ----------------------------------------------------------------------------
module temperature_hysteresis_alarm_logger_unit
   import thal_pkg::*;
#(
   parameter int HISTORY_DEPTH = 64,
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1,
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1),
   localparam int REQ_DATA_W = ((84 + IDX_W + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((81 + CNT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // adc_sample, now_ms, date_year, date_month, date_day, date_hour,
   // date_minute, date_second, read_index
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [CMD_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // temperature, alarm_active, led_on, alarm_count, entry_threshold,
   // entry_year, entry_month, entry_day, entry_hour, entry_minute,
   // entry_second, entry_duration_s
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ITEM_W  = $bits(thal_item_type);
   localparam int QUEUE_W = ITEM_W + IDX_W;

   thal_cfg_type cfg_ff;

   thal_date_type    req_date;
   logic             push_valid;
   thal_item_type    push_item;
   logic [IDX_W-1:0] push_idx;
   logic             head_valid;
   logic [QUEUE_W-1:0] head_data;
   thal_item_type    head_item;
   logic [IDX_W-1:0] head_idx;
   logic             pop;

   thal_status_type  out_status;
   logic [CNT_W-1:0] out_count;
   thal_event_type   out_entry;
   logic [DUR_W-1:0] out_duration;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alarm_threshold   <= 8'sd28;
         cfg_ff.release_threshold <= 8'sd25;
         cfg_ff.blink_period_ms   <= 16'd100;
      end else if (csr_we) begin
         case (thal_csr_type'(csr_addr))
            CSR_ALARM_THRESHOLD:   cfg_ff.alarm_threshold   <= csr_wdata[7:0];
            CSR_RELEASE_THRESHOLD: cfg_ff.release_threshold <= csr_wdata[7:0];
            CSR_BLINK_PERIOD:      cfg_ff.blink_period_ms   <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_date.year   = req_tdata[57:44];
   assign req_date.month  = req_tdata[61:58];
   assign req_date.day    = req_tdata[66:62];
   assign req_date.hour   = req_tdata[71:67];
   assign req_date.minute = req_tdata[77:72];
   assign req_date.second = req_tdata[83:78];

   thal_front #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_cmd        (thal_cmd_type'(req_tuser)),
      .in_sample     (req_tdata[11:0]),
      .in_now        (req_tdata[43:12]),
      .in_date       (req_date),
      .in_idx        (req_tdata[84 +: IDX_W]),
      .credit_return (pop),
      .push_valid    (push_valid),
      .push_item     (push_item),
      .push_idx      (push_idx)
   );

   thal_queue #(
      .WIDTH (QUEUE_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_data  ({push_idx, push_item}),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign head_item = thal_item_type'(head_data[ITEM_W-1:0]);
   assign head_idx  = head_data[ITEM_W +: IDX_W];

   thal_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .blink_period_ms (cfg_ff.blink_period_ms),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_idx        (head_idx),
      .pop             (pop),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .out_status      (out_status),
      .out_count       (out_count),
      .out_entry       (out_entry),
      .out_duration    (out_duration)
   );

   assign rsp_tdata = RSP_DATA_W'({
      out_duration,
      out_entry.date.second,
      out_entry.date.minute,
      out_entry.date.hour,
      out_entry.date.day,
      out_entry.date.month,
      out_entry.date.year,
      out_entry.threshold,
      out_count,
      out_status.led_on,
      out_status.alarm_active,
      out_status.temperature
   });

endmodule
